[rtl/rcpwm_pkg.sv]
// Package for the two-channel RC pulse-width conditioner.
// Holds shared types, fixed limits and small helper functions.
// No dependencies.
`default_nettype none

package rcpwm_pkg;

   localparam logic [11:0] MIN_PULSE_US      = 12'd800;
   localparam logic [11:0] MAX_PULSE_US      = 12'd2400;
   localparam logic [11:0] NEUTRAL_WINDOW_US = 12'd50;
   localparam logic [11:0] MOVE_THRESHOLD_US = 12'd20;
   localparam logic [31:0] FRESH_MS          = 32'd100;
   localparam logic [31:0] MOVE_TIMEOUT_MS   = 32'd200;
   localparam logic [11:0] NEUTRAL_RESET     = 12'd1500;
   localparam logic [15:0] TIMEOUT_RESET     = 16'd500;

   localparam int unsigned CSR_ADDR_WIDTH = 3;

   typedef enum logic {
      REG_NEUTRAL = 1'b0,
      REG_TIMEOUT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [11:0] neutral_us;
      logic [15:0] failsafe_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        ch1_new;
      logic [11:0] ch1_pulse_us;
      logic        ch2_new;
      logic [11:0] ch2_pulse_us;
   } item_type;

   typedef struct packed {
      logic [11:0] ch1_us;
      logic [11:0] ch2_us;
      logic        signal_valid;
      logic [31:0] last_update_ms;
   } result_type;

   function automatic logic [11:0] abs_diff(input logic [11:0] a, input logic [11:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

   // stamp of zero means the event never happened
   function automatic logic recent(input logic [31:0] stamp, input logic [31:0] now,
                                   input logic [31:0] window);
      logic [31:0] age;
      age    = now - stamp;
      recent = (stamp != 32'd0) && (age <= window);
   endfunction

endpackage

`default_nettype wire

[rtl/rc_pwm_two_channel_conditioner_top.sv]
// Two-channel RC pulse-width conditioner with failsafe. Each item is one update tick;
// it gives exactly one result item. An item is captured in an input register; once the
// result slot is free, the state update and result are computed in one pass and loaded
// into the result register, which drives rsp_valid. One item is taken every cycle
// while the result side keeps up. The state feedback through the smoothing adder and
// time compares is the combinational path that sets this rate.
// Registers: 0x0 neutral_us (12 bits, reset 1500), 0x4 failsafe_timeout_ms (16 bits,
// reset 500); write them only while no item is in flight.
// Depends on rcpwm_pkg, rcpwm_csr, rcpwm_chan, rcpwm_state.
`default_nettype none

module rc_pwm_two_channel_conditioner_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [31:0]                           req_now_ms,
   input  wire logic                                  req_ch1_new,
   input  wire logic [11:0]                           req_ch1_pulse_us,
   input  wire logic                                  req_ch2_new,
   input  wire logic [11:0]                           req_ch2_pulse_us,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic      [11:0]                           rsp_ch1_us,
   output logic      [11:0]                           rsp_ch2_us,
   output logic                                       rsp_signal_valid,
   output logic      [31:0]                           rsp_last_update_ms,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [rcpwm_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [31:0]                           csr_pwdata,
   output logic      [31:0]                           csr_prdata,
   output logic                                       csr_pready
);
   import rcpwm_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       in_valid_ff, in_valid_in;
   result_type result_in, result_ff;
   logic       out_valid_ff, out_valid_in;
   logic       advance, req_accept;

   rcpwm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rcpwm_state u_state (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result_in)
   );

   // move the captured item into the result register when that slot frees up
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.now_ms       <= req_now_ms;
         item_ff.ch1_new      <= req_ch1_new;
         item_ff.ch1_pulse_us <= req_ch1_pulse_us;
         item_ff.ch2_new      <= req_ch2_new;
         item_ff.ch2_pulse_us <= req_ch2_pulse_us;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_ch1_us         = result_ff.ch1_us;
   assign rsp_ch2_us         = result_ff.ch2_us;
   assign rsp_signal_valid   = result_ff.signal_valid;
   assign rsp_last_update_ms = result_ff.last_update_ms;

endmodule

`default_nettype wire

[rtl/rcpwm_csr.sv]
// Configuration registers of the RC pulse-width conditioner, APB-style access.
// Depends on rcpwm_pkg.
`default_nettype none

module rcpwm_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [rcpwm_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [31:0]                           csr_pwdata,
   output logic      [31:0]                           csr_prdata,
   output logic                                       csr_pready,
   output rcpwm_pkg::cfg_type                         cfg
);
   import rcpwm_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_NEUTRAL: cfg_in.neutral_us          = csr_pwdata[11:0];
            REG_TIMEOUT: cfg_in.failsafe_timeout_ms = csr_pwdata[15:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_NEUTRAL: csr_prdata = {20'd0, cfg_ff.neutral_us};
         REG_TIMEOUT: csr_prdata = {16'd0, cfg_ff.failsafe_timeout_ms};
         default:     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neutral_us          <= NEUTRAL_RESET;
         cfg_ff.failsafe_timeout_ms <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[rtl/rcpwm_chan.sv]
// One channel's width conditioning: range clamp to neutral and smoothing.
// Depends on rcpwm_pkg.
`default_nettype none

module rcpwm_chan (
   input  wire logic        pulse_new,
   input  wire logic [11:0] pulse_us,
   input  wire logic [11:0] neutral_us,
   input  wire logic [11:0] smooth_ff,
   input  wire logic        seen_ff,
   output logic      [11:0] smooth_in
);
   import rcpwm_pkg::*;

   logic [11:0] clean;
   logic [13:0] sum;

   assign clean = (pulse_us < MIN_PULSE_US || pulse_us > MAX_PULSE_US) ? neutral_us : pulse_us;
   // 3*old + new + 2, then drop two bits
   assign sum   = {2'b00, smooth_ff} + {1'b0, smooth_ff, 1'b0} + {2'b00, clean} + 14'd2;

   always_comb begin
      if (!pulse_new) begin
         smooth_in = smooth_ff;
      end else if (seen_ff) begin
         smooth_in = sum[13:2];
      end else begin
         smooth_in = clean;
      end
   end

endmodule

`default_nettype wire

[rtl/rcpwm_state.sv]
// Per-tick state of the conditioner: smoothed widths, timestamps, movement tracking,
// and the result computed from the updated state. Depends on rcpwm_pkg, rcpwm_chan.
`default_nettype none

module rcpwm_state (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  rcpwm_pkg::item_type        item,
   input  rcpwm_pkg::cfg_type         cfg,
   output rcpwm_pkg::result_type      result
);
   import rcpwm_pkg::*;

   logic [11:0] smooth_one_ff, smooth_one_in, smooth_two_ff, smooth_two_in;
   logic        seen_one_ff, seen_one_in, seen_two_ff, seen_two_in;
   logic [31:0] pulse_time_one_ff, pulse_time_one_in, pulse_time_two_ff, pulse_time_two_in;
   logic [31:0] update_time_ff, update_time_in;
   logic [31:0] move_time_ff, move_time_in;
   logic [11:0] move_ref_one_ff, move_ref_one_in, move_ref_two_ff, move_ref_two_in;

   logic        any_new, moved, fresh, moved_recently, near_neutral, active;
   logic [31:0] update_age;

   rcpwm_chan u_chan_one (
      .pulse_new  (item.ch1_new),
      .pulse_us   (item.ch1_pulse_us),
      .neutral_us (cfg.neutral_us),
      .smooth_ff  (smooth_one_ff),
      .seen_ff    (seen_one_ff),
      .smooth_in  (smooth_one_in)
   );

   rcpwm_chan u_chan_two (
      .pulse_new  (item.ch2_new),
      .pulse_us   (item.ch2_pulse_us),
      .neutral_us (cfg.neutral_us),
      .smooth_ff  (smooth_two_ff),
      .seen_ff    (seen_two_ff),
      .smooth_in  (smooth_two_in)
   );

   always_comb begin
      any_new           = item.ch1_new || item.ch2_new;
      seen_one_in       = seen_one_ff || item.ch1_new;
      seen_two_in       = seen_two_ff || item.ch2_new;
      pulse_time_one_in = item.ch1_new ? item.now_ms : pulse_time_one_ff;
      pulse_time_two_in = item.ch2_new ? item.now_ms : pulse_time_two_ff;
      update_time_in    = any_new ? item.now_ms : update_time_ff;

      moved = any_new &&
              (abs_diff(smooth_one_in, move_ref_one_ff) > MOVE_THRESHOLD_US ||
               abs_diff(smooth_two_in, move_ref_two_ff) > MOVE_THRESHOLD_US);
      move_time_in    = moved ? item.now_ms : move_time_ff;
      move_ref_one_in = moved ? smooth_one_in : move_ref_one_ff;
      move_ref_two_in = moved ? smooth_two_in : move_ref_two_ff;

      fresh = seen_one_in && seen_two_in &&
              recent(pulse_time_one_in, item.now_ms, FRESH_MS) &&
              recent(pulse_time_two_in, item.now_ms, FRESH_MS);
      moved_recently = recent(move_time_in, item.now_ms, MOVE_TIMEOUT_MS);
      near_neutral   = abs_diff(smooth_one_in, cfg.neutral_us) <= NEUTRAL_WINDOW_US &&
                       abs_diff(smooth_two_in, cfg.neutral_us) <= NEUTRAL_WINDOW_US;
      active         = fresh && (!near_neutral || moved_recently);
      update_age     = item.now_ms - update_time_in;

      result.ch1_us         = seen_one_in ? smooth_one_in : cfg.neutral_us;
      result.ch2_us         = seen_two_in ? smooth_two_in : cfg.neutral_us;
      result.signal_valid   = active && (update_age <= {16'd0, cfg.failsafe_timeout_ms});
      result.last_update_ms = update_time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_one_ff     <= NEUTRAL_RESET;
         smooth_two_ff     <= NEUTRAL_RESET;
         seen_one_ff       <= 1'b0;
         seen_two_ff       <= 1'b0;
         pulse_time_one_ff <= 32'd0;
         pulse_time_two_ff <= 32'd0;
         update_time_ff    <= 32'd0;
         move_time_ff      <= 32'd0;
         move_ref_one_ff   <= NEUTRAL_RESET;
         move_ref_two_ff   <= NEUTRAL_RESET;
      end else if (advance) begin
         smooth_one_ff     <= smooth_one_in;
         smooth_two_ff     <= smooth_two_in;
         seen_one_ff       <= seen_one_in;
         seen_two_ff       <= seen_two_in;
         pulse_time_one_ff <= pulse_time_one_in;
         pulse_time_two_ff <= pulse_time_two_in;
         update_time_ff    <= update_time_in;
         move_time_ff      <= move_time_in;
         move_ref_one_ff   <= move_ref_one_in;
         move_ref_two_ff   <= move_ref_two_in;
      end
   end

endmodule

`default_nettype wire

[rtl/rcpwm_checker.sv]
// Port-level checks for the RC pulse-width conditioner, bound to its top level.
// Depends on rc_pwm_two_channel_conditioner_top.
`default_nettype none

module rcpwm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [11:0] rsp_ch1_us,
   input wire logic [11:0] rsp_ch2_us,
   input wire logic        rsp_signal_valid,
   input wire logic [31:0] rsp_last_update_ms
);

   // a draining result side never blocks intake
   assert property (@(posedge clock) disable iff (reset) rsp_ready |-> req_ready)
      else $error("req_ready low while rsp_ready high");

   // valid signal needs a fresh pulse, so the update stamp cannot read as never
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_signal_valid |-> rsp_last_update_ms != 32'd0)
      else $error("signal_valid with last_update_ms of zero");

   // pipeline comes out of reset empty
   assert property (@(posedge clock) $past(reset) && !reset |-> req_ready && !rsp_valid)
      else $error("pipeline not empty after reset");

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ch1_us) &&
                    $stable(rsp_ch2_us) && $stable(rsp_signal_valid) &&
                    $stable(rsp_last_update_ms))
      else $error("result item changed while stalled");

endmodule

bind rc_pwm_two_channel_conditioner_top rcpwm_checker u_rcpwm_checker (.*);

`default_nettype wire
